// ===== hw/rtl/tlsu_pkg.sv =====
`timescale 1ns / 1ps
package tlsu_pkg;

    typedef enum logic [4:0] {
        ACT_LDM      = 5'd0,
        ACT_STM      = 5'd1,
        ACT_POP      = 5'd2,
        ACT_PUSH     = 5'd3,
        ACT_LDR_IMM  = 5'd4,
        ACT_LDR_SP   = 5'd5,
        ACT_LDR_PC   = 5'd6,
        ACT_LDR_REG  = 5'd7,
        ACT_LDRB_IMM = 5'd8,
        ACT_LDRB_REG = 5'd9,
        ACT_LDRH_IMM = 5'd10,
        ACT_LDRH_REG = 5'd11,
        ACT_LDRSB    = 5'd12,
        ACT_LDRSH    = 5'd13,
        ACT_STR_IMM  = 5'd14,
        ACT_STR_SP   = 5'd15,
        ACT_STR_REG  = 5'd16,
        ACT_STRB_IMM = 5'd17,
        ACT_STRB_REG = 5'd18,
        ACT_STRH_IMM = 5'd19,
        ACT_STRH_REG = 5'd20,
        ACT_SET_REG  = 5'd21,
        ACT_PRELOAD  = 5'd22
    } t_action;

    localparam logic [3:0] SP_IDX = 4'd13;
    localparam logic [3:0] LR_IDX = 4'd14;
    localparam logic [3:0] PC_IDX = 4'd15;
    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;

    typedef struct packed {
        logic [4:0]  action;
        logic [3:0]  dest_reg;
        logic [2:0]  base_reg;
        logic [2:0]  offset_reg;
        logic [7:0]  immediate;
        logic [15:0] reg_list;
        logic [31:0] set_value;
        logic [31:0] preload_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] access_address;
        logic [31:0] loaded_value;
        logic [31:0] stored_word;
        logic [31:0] base_after;
        logic [3:0]  words_moved;
        logic        branch_taken;
        logic        malformed;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RBASE,
        ST_RADDR,
        ST_ADDR,
        ST_MREAD,
        ST_MWAIT,
        ST_SINGLE,
        ST_MNEXT,
        ST_MRWAIT,
        ST_MLOAD,
        ST_WBACK,
        ST_DONE
    } t_state;

    // register file port request from sequencer
    typedef struct packed {
        logic        we;
        logic [3:0]  waddr;
        logic [31:0] wdata;
        logic [3:0]  raddr;
    } t_rf_req;

    // memory port request from sequencer
    typedef struct packed {
        logic        we;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_mem_req;

endpackage

// ===== hw/rtl/tlsu_regfile.sv =====
`timescale 1ns / 1ps
module tlsu_regfile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlsu_pkg::t_rf_req i_req,
    output logic [31:0]      o_rdata
);
    logic [31:0] r_regs [16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_regs[k] <= 32'd0;
        end else if (i_req.we) begin
            r_regs[i_req.waddr] <= i_req.wdata;
        end
    end

    assign o_rdata = r_regs[i_req.raddr];
endmodule

// ===== hw/rtl/tlsu_mem.sv =====
`timescale 1ns / 1ps
module tlsu_mem #(
    parameter int MEM_WORDS = 1024
) (
    input  logic              i_clk,
    input  tlsu_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic [31:0] r_mem [MEM_WORDS];
    logic [29:0] widx;
    logic        in_range;

    assign widx     = i_req.addr[31:2];
    assign in_range = ({2'b00, widx} < 32'(MEM_WORDS));

    always_ff @(posedge i_clk) begin
        if (i_req.we && in_range) r_mem[widx[AW-1:0]] <= i_req.wdata;
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= in_range ? r_mem[widx[AW-1:0]] : 32'd0;
    end
endmodule

// ===== hw/rtl/thumb_load_store_unit_core.sv =====
`timescale 1ns / 1ps
// Thumb load/store unit with a 16-entry register file and a word memory.
// Input: drive i_item and raise start while busy is low; the transaction is
// taken at that edge and busy rises the next cycle.
// Output: o_done pulses for one cycle with o_result; the receiver cannot
// stall, so the result must be taken in that cycle.
// Steps from the accepting edge to o_done: set actions, unknown actions and
// a malformed stm go from ST_RBASE straight to ST_DONE; single loads and
// stores pass ST_RADDR, ST_ADDR, ST_MREAD and ST_SINGLE; ldm, stm, pop and
// push visit each list position in ST_MNEXT, plus ST_MRWAIT and ST_MLOAD for
// each register loaded; all share one register-file port and one memory port.
// busy drops the cycle after o_done; one transaction at a time.
// Reset (i_rst_n low, synchronous) clears the register file at once, then
// a clearing pass writes zero to each memory word in turn, with busy high
// throughout.
// Memory words at or beyond MEM_WORDS read as zero and ignore writes.
module thumb_load_store_unit_core #(
    parameter int MEM_WORDS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tlsu_pkg::t_in_item    i_item,
    output logic                  o_done,
    output tlsu_pkg::t_out_item   o_result
);
    localparam int CW = $clog2(MEM_WORDS + 1);

    tlsu_pkg::t_state   r_state, n_state;
    tlsu_pkg::t_in_item r_item, n_item;
    tlsu_pkg::t_rf_req  rf_req;
    tlsu_pkg::t_mem_req mem_req;
    logic [31:0] rf_rdata, mem_rdata;

    logic [CW-1:0] r_clr, n_clr;
    logic [31:0] r_base, n_base;   // base register value, later the old memory word
    logic [31:0] r_addr, n_addr;   // running address / effective address
    logic [31:0] r_word, n_word;
    logic [4:0]  r_idx, n_idx;     // list walk position
    logic [3:0]  r_moved, n_moved;
    logic        r_br, n_br;
    tlsu_pkg::t_out_item r_res, n_res;
    logic        r_done, n_done;

    tlsu_regfile u_rf (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(rf_req), .o_rdata(rf_rdata));
    tlsu_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
        .i_clk(i_clk), .i_req(mem_req), .o_rdata(mem_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlsu_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_base  <= n_base;
        r_addr  <= n_addr;
        r_word  <= n_word;
        r_idx   <= n_idx;
        r_moved <= n_moved;
        r_br    <= n_br;
        r_res   <= n_res;
    end

    logic [4:0]  act;
    logic [15:0] lmask;
    logic        is_multi, is_load, listed, last;
    logic [31:0] off, lane_val, dmask;
    logic [4:0]  bsh;
    logic [7:0]  l8;
    logic [7:0]  lowest;

    always_comb begin
        act   = r_item.action;
        l8    = r_item.reg_list[7:0];
        lowest = l8 & (~l8 + 8'd1);
        case (act)
            tlsu_pkg::ACT_POP:  lmask = r_item.reg_list & 16'h80FF;
            tlsu_pkg::ACT_PUSH: lmask = r_item.reg_list & 16'h40FF;
            default:            lmask = {8'd0, l8};
        endcase
        is_multi = (act <= 5'd3);
        is_load  = (act <= 5'd13);
        listed   = lmask[r_idx[3:0]];
        last     = (act == tlsu_pkg::ACT_PUSH) ? (r_idx == 5'd0) : (r_idx == 5'd15);
        case (act)
            tlsu_pkg::ACT_LDR_IMM, tlsu_pkg::ACT_STR_IMM,
            tlsu_pkg::ACT_LDR_SP, tlsu_pkg::ACT_STR_SP,
            tlsu_pkg::ACT_LDR_PC:                     off = {22'd0, r_item.immediate, 2'b00};
            tlsu_pkg::ACT_LDRB_IMM, tlsu_pkg::ACT_STRB_IMM: off = {24'd0, r_item.immediate};
            tlsu_pkg::ACT_LDRH_IMM, tlsu_pkg::ACT_STRH_IMM: off = {23'd0, r_item.immediate, 1'b0};
            default:                                  off = rf_rdata;
        endcase
        bsh = {r_addr[1:0], 3'b000};
        case (act)
            tlsu_pkg::ACT_LDRB_IMM, tlsu_pkg::ACT_LDRB_REG:
                lane_val = {24'd0, 8'(r_word >> bsh)};
            tlsu_pkg::ACT_LDRSB:
                lane_val = {{24{r_word[bsh+7]}}, 8'(r_word >> bsh)};
            tlsu_pkg::ACT_LDRH_IMM, tlsu_pkg::ACT_LDRH_REG:
                lane_val = r_addr[1] ? {16'd0, r_word[31:16]} : {16'd0, r_word[15:0]};
            tlsu_pkg::ACT_LDRSH:
                lane_val = r_addr[1] ? {{16{r_word[31]}}, r_word[31:16]}
                                     : {{16{r_word[15]}}, r_word[15:0]};
            default: lane_val = r_word;
        endcase
        case (act)
            tlsu_pkg::ACT_STRB_IMM, tlsu_pkg::ACT_STRB_REG:
                dmask = 32'h0000_00FF << bsh;
            tlsu_pkg::ACT_STRH_IMM, tlsu_pkg::ACT_STRH_REG:
                dmask = r_addr[1] ? 32'hFFFF_0000 : 32'h0000_FFFF;
            default: dmask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_item  = r_item;
        n_base  = r_base;
        n_addr  = r_addr;
        n_word  = r_word;
        n_idx   = r_idx;
        n_moved = r_moved;
        n_br    = r_br;
        n_res   = r_res;
        n_done  = 1'b0;
        rf_req  = '0;
        mem_req = '0;
        busy    = 1'b1;

        case (r_state)
            tlsu_pkg::ST_CLEAR: begin
                mem_req.we   = 1'b1;
                mem_req.addr = 32'(r_clr) << 2;
                n_clr = r_clr + 1'b1;
                if (r_clr == CW'(MEM_WORDS - 1)) n_state = tlsu_pkg::ST_IDLE;
            end
            tlsu_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_item  = i_item;
                    n_res   = '0;
                    n_moved = 4'd0;
                    n_br    = 1'b0;
                    n_state = tlsu_pkg::ST_RBASE;
                end
            end
            tlsu_pkg::ST_RBASE: begin
                // fetch base register
                case (act)
                    tlsu_pkg::ACT_POP, tlsu_pkg::ACT_PUSH,
                    tlsu_pkg::ACT_LDR_SP, tlsu_pkg::ACT_STR_SP: rf_req.raddr = tlsu_pkg::SP_IDX;
                    tlsu_pkg::ACT_LDR_PC: rf_req.raddr = tlsu_pkg::PC_IDX;
                    default: rf_req.raddr = {1'b0, r_item.base_reg};
                endcase
                n_base = (act == tlsu_pkg::ACT_LDR_PC) ? (rf_rdata & tlsu_pkg::ALIGN_MASK)
                                                      : rf_rdata;
                n_addr = n_base;
                n_idx  = (act == tlsu_pkg::ACT_PUSH) ? 5'd14 : 5'd0;
                if (act == tlsu_pkg::ACT_SET_REG) begin
                    rf_req.we    = 1'b1;
                    rf_req.waddr = r_item.dest_reg;
                    rf_req.wdata = r_item.set_value;
                    n_state = tlsu_pkg::ST_DONE;
                end else if (act == tlsu_pkg::ACT_PRELOAD) begin
                    mem_req.we    = 1'b1;
                    mem_req.addr  = r_item.preload_address & tlsu_pkg::ALIGN_MASK;
                    mem_req.wdata = r_item.set_value;
                    n_state = tlsu_pkg::ST_DONE;
                end else if (act > 5'd22) begin
                    n_state = tlsu_pkg::ST_DONE;
                end else if (is_multi) begin
                    n_res.access_address = rf_rdata & tlsu_pkg::ALIGN_MASK;
                    if (act == tlsu_pkg::ACT_STM && l8 != 8'd0
                        && lowest == (8'd1 << r_item.base_reg)) begin
                        n_res.malformed  = 1'b1;
                        n_res.base_after = rf_rdata;
                        n_state = tlsu_pkg::ST_DONE;
                    end else begin
                        n_state = tlsu_pkg::ST_MNEXT;
                    end
                end else begin
                    n_state = tlsu_pkg::ST_RADDR;
                end
            end
            tlsu_pkg::ST_RADDR: begin
                rf_req.raddr = {1'b0, r_item.offset_reg};
                n_addr = r_base + off;
                n_state = tlsu_pkg::ST_ADDR;
            end
            tlsu_pkg::ST_ADDR: begin
                rf_req.raddr = r_item.dest_reg;
                n_word = rf_rdata;   // store data
                mem_req.addr = r_addr & tlsu_pkg::ALIGN_MASK;
                n_state = tlsu_pkg::ST_MREAD;
            end
            tlsu_pkg::ST_MREAD: begin
                n_base  = mem_rdata;
                n_state = tlsu_pkg::ST_SINGLE;
                n_res.access_address = r_addr & tlsu_pkg::ALIGN_MASK;
                n_res.words_moved    = 4'd1;
                if (is_load) n_word = mem_rdata;
            end
            tlsu_pkg::ST_SINGLE: begin
                if (is_load) begin
                    rf_req.we    = 1'b1;
                    rf_req.waddr = r_item.dest_reg;
                    rf_req.wdata = lane_val;
                    n_res.loaded_value = lane_val;
                end else begin
                    // r_base holds old memory word, r_word the register data
                    mem_req.we    = 1'b1;
                    mem_req.addr  = r_addr & tlsu_pkg::ALIGN_MASK;
                    case (act)
                        tlsu_pkg::ACT_STRB_IMM, tlsu_pkg::ACT_STRB_REG:
                            mem_req.wdata = (r_base & ~dmask) | ((r_word << bsh) & dmask);
                        tlsu_pkg::ACT_STRH_IMM, tlsu_pkg::ACT_STRH_REG:
                            mem_req.wdata = (r_base & ~dmask)
                                | (r_addr[1] ? {r_word[15:0], 16'd0} : {16'd0, r_word[15:0]});
                        default: mem_req.wdata = r_word;
                    endcase
                    n_res.stored_word = mem_req.wdata;
                end
                n_state = tlsu_pkg::ST_DONE;
            end
            tlsu_pkg::ST_MNEXT: begin
                // one list position per visit
                if (listed) begin
                    if (act == tlsu_pkg::ACT_STM || act == tlsu_pkg::ACT_PUSH) begin
                        rf_req.raddr  = r_idx[3:0];
                        mem_req.we    = 1'b1;
                        mem_req.addr  = ((act == tlsu_pkg::ACT_PUSH) ? r_addr - 32'd4 : r_addr)
                                        & tlsu_pkg::ALIGN_MASK;
                        mem_req.wdata = rf_rdata;
                        n_addr  = (act == tlsu_pkg::ACT_PUSH) ? r_addr - 32'd4
                                                              : r_addr + 32'd4;
                        n_moved = r_moved + 4'd1;
                    end else begin
                        mem_req.addr = r_addr & tlsu_pkg::ALIGN_MASK;
                        n_state = tlsu_pkg::ST_MRWAIT;
                    end
                end
                if (!(listed && (act == tlsu_pkg::ACT_LDM || act == tlsu_pkg::ACT_POP))) begin
                    if (last) n_state = tlsu_pkg::ST_WBACK;
                    else n_idx = (act == tlsu_pkg::ACT_PUSH) ? r_idx - 5'd1 : r_idx + 5'd1;
                end
            end
            tlsu_pkg::ST_MRWAIT: begin
                n_word  = mem_rdata;
                n_state = tlsu_pkg::ST_MLOAD;
            end
            tlsu_pkg::ST_MLOAD: begin
                rf_req.we    = 1'b1;
                rf_req.waddr = r_idx[3:0];
                rf_req.wdata = r_word;
                n_addr  = r_addr + 32'd4;
                n_moved = r_moved + 4'd1;
                if (r_idx[3:0] == tlsu_pkg::PC_IDX) n_br = 1'b1;
                if (last) n_state = tlsu_pkg::ST_WBACK;
                else begin
                    n_idx = r_idx + 5'd1;
                    n_state = tlsu_pkg::ST_MNEXT;
                end
            end
            tlsu_pkg::ST_WBACK: begin
                rf_req.raddr = {1'b0, r_item.base_reg};
                n_res.words_moved  = r_moved;
                n_res.branch_taken = r_br;
                case (act)
                    tlsu_pkg::ACT_LDM: begin
                        if (l8[r_item.base_reg]) n_res.base_after = rf_rdata;
                        else begin
                            rf_req.we    = 1'b1;
                            rf_req.waddr = {1'b0, r_item.base_reg};
                            rf_req.wdata = r_addr;
                            n_res.base_after = r_addr;
                        end
                    end
                    tlsu_pkg::ACT_STM: begin
                        rf_req.we    = 1'b1;
                        rf_req.waddr = {1'b0, r_item.base_reg};
                        rf_req.wdata = r_addr;
                        n_res.base_after = r_addr;
                    end
                    default: begin
                        rf_req.we    = 1'b1;
                        rf_req.waddr = tlsu_pkg::SP_IDX;
                        rf_req.wdata = r_addr;
                        n_res.base_after = r_addr;
                        if (act == tlsu_pkg::ACT_PUSH)
                            n_res.access_address = r_addr & tlsu_pkg::ALIGN_MASK;
                    end
                endcase
                n_state = tlsu_pkg::ST_DONE;
            end
            tlsu_pkg::ST_DONE: begin
                n_done  = 1'b1;
                n_state = tlsu_pkg::ST_MWAIT;
            end
            tlsu_pkg::ST_MWAIT: begin
                n_state = tlsu_pkg::ST_IDLE;
            end
            default: n_state = tlsu_pkg::ST_IDLE;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

// ===== tb/tb_thumb_load_store_unit_core.sv =====
`timescale 1ns / 1ps
module tb_thumb_load_store_unit_core;

    localparam int MEM_WORDS = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM = 680;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    tlsu_pkg::t_in_item   i_item;
    logic                 o_done;
    tlsu_pkg::t_out_item  o_result;

    thumb_load_store_unit_core #(.MEM_WORDS(MEM_WORDS)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_done(o_done),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // shadow state of the unit
    logic [31:0]         shadow_regs [16];
    logic [31:0]         shadow_mem [MEM_WORDS];
    tlsu_pkg::t_out_item pending_results [$];
    int                  fail_count;
    int                  idle_cycles;
    int                  send_idle_pct;

    function automatic logic [31:0] mem_rd(input logic [31:0] a);
        if ((a >> 2) < MEM_WORDS) return shadow_mem[a >> 2];
        return 32'd0;
    endfunction

    task automatic mem_wr(input logic [31:0] a, input logic [31:0] v);
        if ((a >> 2) < MEM_WORDS) shadow_mem[a >> 2] = v;
    endtask

    task automatic execute_instr(input tlsu_pkg::t_in_item it,
                                 output tlsu_pkg::t_out_item r);
        logic [31:0]       addr;
        logic [31:0]       ea;
        logic [31:0]       word;
        logic [31:0]       data;
        logic [15:0]       lst;
        logic [7:0]        lowest;
        logic [4:0]        sh;
        tlsu_pkg::t_action act;
        r = '0;
        act = tlsu_pkg::t_action'(it.action);
        case (act)
            tlsu_pkg::ACT_LDM: begin
                addr = shadow_regs[it.base_reg];
                r.access_address = addr & tlsu_pkg::ALIGN_MASK;
                for (int i = 0; i < 8; i++) begin
                    if (it.reg_list[i]) begin
                        shadow_regs[i] = mem_rd(addr & tlsu_pkg::ALIGN_MASK);
                        addr += 4;
                        r.words_moved++;
                    end
                end
                if (!it.reg_list[it.base_reg]) shadow_regs[it.base_reg] = addr;
                r.base_after = shadow_regs[it.base_reg];
            end
            tlsu_pkg::ACT_STM: begin
                lowest = it.reg_list[7:0] & (8'd0 - it.reg_list[7:0]);
                addr = shadow_regs[it.base_reg];
                r.access_address = addr & tlsu_pkg::ALIGN_MASK;
                if (lowest == (8'd1 << it.base_reg)) begin
                    r.malformed = 1'b1;
                end else begin
                    for (int i = 0; i < 8; i++) begin
                        if (it.reg_list[i]) begin
                            mem_wr(addr & tlsu_pkg::ALIGN_MASK, shadow_regs[i]);
                            addr += 4;
                            r.words_moved++;
                        end
                    end
                    shadow_regs[it.base_reg] = addr;
                end
                r.base_after = shadow_regs[it.base_reg];
            end
            tlsu_pkg::ACT_POP: begin
                lst = it.reg_list & 16'h80FF;
                addr = shadow_regs[tlsu_pkg::SP_IDX];
                r.access_address = addr & tlsu_pkg::ALIGN_MASK;
                for (int i = 0; i < 16; i++) begin
                    if (lst[i]) begin
                        shadow_regs[i] = mem_rd(addr & tlsu_pkg::ALIGN_MASK);
                        addr += 4;
                        r.words_moved++;
                        if (i == tlsu_pkg::PC_IDX) r.branch_taken = 1'b1;
                    end
                end
                shadow_regs[tlsu_pkg::SP_IDX] = addr;
                r.base_after = addr;
            end
            tlsu_pkg::ACT_PUSH: begin
                lst = it.reg_list & 16'h40FF;
                addr = shadow_regs[tlsu_pkg::SP_IDX];
                for (int i = 14; i >= 0; i--) begin
                    if (lst[i]) begin
                        addr -= 4;
                        mem_wr(addr & tlsu_pkg::ALIGN_MASK, shadow_regs[i]);
                        r.words_moved++;
                    end
                end
                shadow_regs[tlsu_pkg::SP_IDX] = addr;
                r.base_after = addr;
                r.access_address = addr & tlsu_pkg::ALIGN_MASK;
            end
            tlsu_pkg::ACT_SET_REG: shadow_regs[it.dest_reg] = it.set_value;
            tlsu_pkg::ACT_PRELOAD:
                mem_wr(it.preload_address & tlsu_pkg::ALIGN_MASK, it.set_value);
            default: begin
                if (it.action > tlsu_pkg::ACT_STRH_REG) return;
                case (act)
                    tlsu_pkg::ACT_LDR_IMM, tlsu_pkg::ACT_STR_IMM:
                        ea = shadow_regs[it.base_reg] + {it.immediate, 2'b00};
                    tlsu_pkg::ACT_LDR_SP, tlsu_pkg::ACT_STR_SP:
                        ea = shadow_regs[tlsu_pkg::SP_IDX] + {it.immediate, 2'b00};
                    tlsu_pkg::ACT_LDR_PC:
                        ea = (shadow_regs[tlsu_pkg::PC_IDX] & tlsu_pkg::ALIGN_MASK)
                             + {it.immediate, 2'b00};
                    tlsu_pkg::ACT_LDRB_IMM, tlsu_pkg::ACT_STRB_IMM:
                        ea = shadow_regs[it.base_reg] + it.immediate;
                    tlsu_pkg::ACT_LDRH_IMM, tlsu_pkg::ACT_STRH_IMM:
                        ea = shadow_regs[it.base_reg] + {it.immediate, 1'b0};
                    default:
                        ea = shadow_regs[it.base_reg] + shadow_regs[it.offset_reg];
                endcase
                r.access_address = ea & tlsu_pkg::ALIGN_MASK;
                r.words_moved = 4'd1;
                word = mem_rd(r.access_address);
                sh = {ea[1:0], 3'b000};
                if (it.action <= tlsu_pkg::ACT_LDRSH) begin
                    case (act)
                        tlsu_pkg::ACT_LDRB_IMM, tlsu_pkg::ACT_LDRB_REG:
                            r.loaded_value = {24'd0, word[sh +: 8]};
                        tlsu_pkg::ACT_LDRSB:
                            r.loaded_value = {{24{word[sh + 7]}}, word[sh +: 8]};
                        tlsu_pkg::ACT_LDRH_IMM, tlsu_pkg::ACT_LDRH_REG:
                            r.loaded_value = {16'd0, word[{ea[1], 4'd0} +: 16]};
                        tlsu_pkg::ACT_LDRSH:
                            r.loaded_value = {{16{word[{ea[1], 4'd15}]}},
                                              word[{ea[1], 4'd0} +: 16]};
                        default: r.loaded_value = word;
                    endcase
                    shadow_regs[it.dest_reg] = r.loaded_value;
                end else begin
                    data = shadow_regs[it.dest_reg];
                    r.stored_word = word;
                    case (act)
                        tlsu_pkg::ACT_STRB_IMM, tlsu_pkg::ACT_STRB_REG:
                            r.stored_word[sh +: 8] = data[7:0];
                        tlsu_pkg::ACT_STRH_IMM, tlsu_pkg::ACT_STRH_REG:
                            r.stored_word[{ea[1], 4'd0} +: 16] = data[15:0];
                        default: r.stored_word = data;
                    endcase
                    mem_wr(r.access_address, r.stored_word);
                end
            end
        endcase
    endtask

    // result checking
    always @(posedge i_clk) begin
        tlsu_pkg::t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, o_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.access_address !== want.access_address) begin
                    $display("%0t: access_address expected %h actual %h", $time,
                             want.access_address, o_result.access_address);
                    fail_count++;
                end
                if (o_result.loaded_value !== want.loaded_value) begin
                    $display("%0t: loaded_value expected %h actual %h", $time,
                             want.loaded_value, o_result.loaded_value);
                    fail_count++;
                end
                if (o_result.stored_word !== want.stored_word) begin
                    $display("%0t: stored_word expected %h actual %h", $time,
                             want.stored_word, o_result.stored_word);
                    fail_count++;
                end
                if (o_result.base_after !== want.base_after) begin
                    $display("%0t: base_after expected %h actual %h", $time,
                             want.base_after, o_result.base_after);
                    fail_count++;
                end
                if (o_result.words_moved !== want.words_moved) begin
                    $display("%0t: words_moved expected %0d actual %0d", $time,
                             want.words_moved, o_result.words_moved);
                    fail_count++;
                end
                if (o_result.branch_taken !== want.branch_taken) begin
                    $display("%0t: branch_taken expected %b actual %b", $time,
                             want.branch_taken, o_result.branch_taken);
                    fail_count++;
                end
                if (o_result.malformed !== want.malformed) begin
                    $display("%0t: malformed expected %b actual %b", $time,
                             want.malformed, o_result.malformed);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_instr(input tlsu_pkg::t_in_item it, input logic check_direct,
                              input tlsu_pkg::t_out_item direct_res);
        tlsu_pkg::t_out_item r;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        execute_instr(it, r);
        if (check_direct && r !== direct_res) begin
            $display("%0t: directed row expected %h actual prediction %h",
                     $time, direct_res, r);
            fail_count++;
        end
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    function automatic tlsu_pkg::t_in_item mk(input tlsu_pkg::t_action a,
                                              input logic [3:0] rd,
                                              input logic [2:0] rn, input logic [2:0] rm,
                                              input logic [7:0] imm, input logic [15:0] lst,
                                              input logic [31:0] v, input logic [31:0] pa);
        tlsu_pkg::t_in_item it;
        it.action = a;
        it.dest_reg = rd;
        it.base_reg = rn;
        it.offset_reg = rm;
        it.immediate = imm;
        it.reg_list = lst;
        it.set_value = v;
        it.preload_address = pa;
        return it;
    endfunction

    // small addresses keep most traffic inside memory
    function automatic logic [31:0] rand_addr();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'hFFFF_FFFC - $urandom_range(64);
            default: return $urandom_range(MEM_WORDS * 4 - 1);
        endcase
    endfunction

    function automatic tlsu_pkg::t_in_item rand_instr();
        tlsu_pkg::t_in_item it;
        it = {$urandom(), $urandom(), $urandom()};
        case ($urandom_range(9))
            0: it.action = tlsu_pkg::ACT_SET_REG;
            1: it.action = tlsu_pkg::ACT_PRELOAD;
            2: it.action = $urandom_range(23, 31);
            default: it.action = $urandom_range(tlsu_pkg::ACT_STRH_REG);
        endcase
        if (it.action == tlsu_pkg::ACT_SET_REG && $urandom_range(3) != 0)
            it.set_value = rand_addr();
        if (it.action == tlsu_pkg::ACT_PRELOAD && $urandom_range(3) != 0)
            it.preload_address = rand_addr();
        if (it.action == tlsu_pkg::ACT_SET_REG && $urandom_range(1))
            it.dest_reg = $urandom_range(7) | ($urandom_range(1) ? 4'd8 : 4'd0);
        return it;
    endfunction

    typedef struct {
        tlsu_pkg::t_in_item  it;
        logic                check;
        tlsu_pkg::t_out_item res;
    } t_row;

    t_row directed_rows [$];

    initial begin
        t_row row;
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 36;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset everything reads zero
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDR_IMM, 4'd1, 3'd0, 3'd0, 8'hFF, 0, 0, 0),
                                  1'b1, '{32'h3FC, 0, 0, 0, 4'd1, 1'b0, 1'b0}});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_PRELOAD, 0, 0, 0, 0, 0, 32'h8081_7F80,
                                     32'h13), 1'b1, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_SET_REG, 4'd2, 0, 0, 0, 0, 32'h11, 0),
                                  1'b1, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDRSB, 4'd3, 3'd2, 3'd0, 0, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDRSH, 4'd4, 3'd2, 3'd2, 0, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDRB_IMM, 4'd5, 3'd2, 0, 8'd2, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDRH_REG, 4'd6, 3'd2, 3'd0, 0, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDRH_IMM, 4'd6, 3'd2, 0, 8'd1, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDR_REG, 4'd7, 3'd2, 3'd3, 0, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_SET_REG, 4'd15, 0, 0, 0, 0, 32'h17, 0),
                                  1, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDR_PC, 4'd8, 0, 0, 8'd0, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_SET_REG, 4'd13, 0, 0, 0, 0, 32'h200, 0),
                                  1, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_PUSH, 0, 0, 0, 0, 16'hFFFF, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_POP, 0, 0, 0, 0, 16'hFFFF, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STR_SP, 4'd9, 0, 0, 8'hFF, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDR_SP, 4'd10, 0, 0, 8'hFF, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STRB_REG, 4'd4, 3'd2, 3'd0, 0, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STRH_IMM, 4'd3, 3'd2, 0, 8'd1, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STRB_IMM, 4'd3, 3'd2, 0, 8'hFF, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STRH_REG, 4'd3, 3'd2, 3'd2, 0, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STR_IMM, 4'd3, 3'd2, 0, 0, 0, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STR_REG, 4'd3, 3'd2, 3'd1, 0, 0, 0, 0),
                                  0, '0});
        // malformed stm: base first in the list
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STM, 0, 3'd2, 0, 0, 16'h00FC, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_STM, 0, 3'd2, 0, 0, 16'h0006, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDM, 0, 3'd2, 0, 0, 16'h0004, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::ACT_LDM, 0, 3'd1, 0, 0, 16'h0000, 0, 0),
                                  0, '0});
        directed_rows.push_back('{mk(tlsu_pkg::t_action'(5'd31), 0, 0, 0, 0, 0, 0, 0),
                                  1, '0});

        foreach (directed_rows[k])
            send_instr(directed_rows[k].it, directed_rows[k].check, directed_rows[k].res);

        // hold off until the unit has drained
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) send_idle_pct = 65;
            if (n == 2 * N_RANDOM / 3) send_idle_pct = 0;
            send_instr(rand_instr(), 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
